@@ src/assert_macros.svh @@
// Assertion macros shared by the cache RTL.
// Both expect clk and rst in scope; rst disables checking.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TCB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache assertion failed");

// Next-cycle implication
`define TCB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache assertion failed");

`endif

@@ src/tcb_pkg.sv @@
// Package for the two-way write-back cache: defaults, codes and FSM states.
// No dependencies.
`timescale 1ns / 1ps
package tcb_pkg;

  localparam int SET_COUNT_DEF    = 64;
  localparam int LINE_BYTES_DEF   = 64;
  localparam int MEMORY_BYTES_DEF = 65536;

  localparam logic [1:0] MODE_READ    = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_PRELOAD = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  localparam logic PORT_DATA = 1'b0;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_PRE,
    ST_LOOK,
    ST_CMP,
    ST_WB,
    ST_FILL,
    ST_ACC,
    ST_RDW,
    ST_DONE
  } state_t;

endpackage

@@ src/tcb_if.sv @@
// Request and response channel interfaces for the cache.
// No dependencies.
`timescale 1ns / 1ps
interface tcb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        port;
  logic [1:0]  access_size;
  logic [31:0] address;
  logic [31:0] write_data;
  modport source (output valid, mode, port, access_size, address, write_data, input ready);
  modport sink   (input valid, mode, port, access_size, address, write_data, output ready);
endinterface

interface tcb_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        all_hit;
  logic        dirty_evicted;
  modport source (output valid, read_data, all_hit, dirty_evicted, input ready);
  modport sink   (input valid, read_data, all_hit, dirty_evicted, output ready);
endinterface

@@ src/tcb_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module tcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/two_way_writeback_cache_top.sv @@
// Two-way write-back data and program caches over a shared backing memory.
// Depends on tcb_pkg, tcb_if, tcb_ram and assert_macros.svh.
//
// Usage: one request beat on req (mode, port, access_size, address, write_data)
// gives one response beat on rsp (read_data, all_hit, dirty_evicted). One
// request is in flight at a time; req.ready is high only while the block idles.
// Each byte of an access is looked up in turn: a write hit steps through tag
// read, compare and line access, and a read hit adds a read capture. A miss
// also fills the line from backing memory, after writing the victim back if it
// is dirty; the byte-wide line and backing RAM ports move the line a byte at a
// time. A preload writes one byte per cycle.
// After reset the backing memory is cleared one byte a cycle with req.ready
// low. Valid, dirty and LRU bits clear in the same pass.
// If rsp.ready is low the response holds and no new request is taken.
// SET_COUNT, LINE_BYTES and MEMORY_BYTES must be powers of two.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module two_way_writeback_cache_top #(
  parameter int SET_COUNT    = tcb_pkg::SET_COUNT_DEF,
  parameter int LINE_BYTES   = tcb_pkg::LINE_BYTES_DEF,
  parameter int MEMORY_BYTES = tcb_pkg::MEMORY_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tcb_req_if.sink   req,
  tcb_rsp_if.source rsp
);
  localparam int OFFW  = $clog2(LINE_BYTES);
  localparam int SETW  = $clog2(SET_COUNT);
  localparam int TAGW  = 32 - OFFW - SETW;
  localparam int MEMW  = $clog2(MEMORY_BYTES);
  localparam int LDEP  = 4 * SET_COUNT * LINE_BYTES;
  localparam int LAW   = $clog2(LDEP);
  localparam int SDEP  = 2 * SET_COUNT;
  localparam int SIW   = SETW + 1;
  localparam logic [OFFW:0] LINE_END = (OFFW+1)'(LINE_BYTES);

  tcb_pkg::state_t state, state_next;

  logic            op_port;
  logic            op_write;
  logic [2:0]      op_n;
  logic [31:0]     op_addr;
  logic [31:0]     op_wdata;
  logic [2:0]      byte_i;
  logic [31:0]     acc;
  logic            hit_all;
  logic            wb_any;
  logic            way;
  logic [TAGW-1:0] vtag;
  logic [OFFW:0]   cnt;
  logic [MEMW-1:0] clr_cnt;

  // current byte address split
  logic [31:0]     cur;
  logic [OFFW-1:0] off;
  logic [SETW-1:0] idx;
  logic [TAGW-1:0] tag;
  logic [SIW-1:0]  s;
  logic [OFFW-1:0] cnt_lo, cnt_prev;
  logic [1:0]      sh;
  logic [7:0]      wbyte;

  assign cur      = op_addr + 32'(byte_i);
  assign off      = cur[OFFW-1:0];
  assign idx      = cur[OFFW +: SETW];
  assign tag      = cur[31 -: TAGW];
  assign s        = {op_port, idx};
  assign cnt_lo   = cnt[OFFW-1:0];
  assign cnt_prev = cnt_lo - 1'b1;
  assign sh       = 2'(op_n - 3'd1 - byte_i);
  assign wbyte    = 8'(op_wdata >> {sh, 3'b000});

  // tag stores, one per way
  logic [TAGW-1:0] tag_rd0, tag_rd1;
  logic            tag_we;
  logic [TAGW-1:0] vict_tag;

  tcb_ram #(.WIDTH(TAGW), .DEPTH(SDEP)) u_tag0 (
    .clk(clk), .we(tag_we && !way), .waddr(s), .wdata(tag), .raddr(s), .rdata(tag_rd0)
  );
  tcb_ram #(.WIDTH(TAGW), .DEPTH(SDEP)) u_tag1 (
    .clk(clk), .we(tag_we && way), .waddr(s), .wdata(tag), .raddr(s), .rdata(tag_rd1)
  );

  // set state store: {lru, dirty[1:0], valid[1:0]} per set
  logic           meta_we;
  logic [SIW-1:0] meta_waddr;
  logic [4:0]     meta_upd, meta_rd, meta;
  logic [1:0]     m_vld, m_dirty;
  logic           m_lru;

  tcb_ram #(.WIDTH(5), .DEPTH(SDEP)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_upd),
    .raddr(s), .rdata(meta_rd)
  );

  assign m_vld   = meta_rd[1:0];
  assign m_dirty = meta_rd[3:2];
  assign m_lru   = meta_rd[4];

  // line store, both caches
  logic           line_we;
  logic [LAW-1:0] line_waddr, line_raddr;
  logic [7:0]     line_wdata, line_rdata;

  tcb_ram #(.WIDTH(8), .DEPTH(LDEP)) u_lines (
    .clk(clk), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
    .raddr(line_raddr), .rdata(line_rdata)
  );

  // backing memory
  logic            bm_we;
  logic [MEMW-1:0] bm_waddr, bm_raddr;
  logic [7:0]      bm_wdata, bm_rdata;
  logic [31:0]     wb_full, fill_full;

  assign wb_full   = {vtag, idx, cnt_prev};
  assign fill_full = {tag, idx, cnt_lo};

  tcb_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_bmem (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  logic h0, h1, vic, vic_dirty, last_byte;
  assign h0        = m_vld[0] && (tag_rd0 == tag);
  assign h1        = m_vld[1] && (tag_rd1 == tag);
  assign vic       = !m_vld[0] ? 1'b0 : (!m_vld[1] ? 1'b1 : m_lru);
  assign vic_dirty = m_vld[vic] && m_dirty[vic];
  assign vict_tag  = vic ? tag_rd1 : tag_rd0;
  assign last_byte = (byte_i + 3'd1) == op_n;

  assign req.ready         = (state == tcb_pkg::ST_IDLE);
  assign rsp.valid         = (state == tcb_pkg::ST_DONE);
  assign rsp.read_data     = acc;
  assign rsp.all_hit       = hit_all;
  assign rsp.dirty_evicted = wb_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcb_pkg::ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tag_we     = 1'b0;
    line_we    = 1'b0;
    line_waddr = {op_port, idx, way, cnt_prev};
    line_wdata = bm_rdata;
    line_raddr = {op_port, idx, way, off};
    bm_we      = 1'b0;
    bm_waddr   = clr_cnt;
    bm_wdata   = 8'h00;
    bm_raddr   = fill_full[MEMW-1:0];
    meta_we    = 1'b0;
    meta_waddr = s;
    meta_upd   = meta;
    unique case (state)
      tcb_pkg::ST_CLR: begin
        bm_we      = 1'b1;
        meta_we    = 1'b1;
        meta_waddr = clr_cnt[SIW-1:0];
        meta_upd   = '0;
        if (&clr_cnt) begin
          state_next = tcb_pkg::ST_IDLE;
        end
      end
      tcb_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (req.mode == tcb_pkg::MODE_PRELOAD) begin
            state_next = tcb_pkg::ST_PRE;
          end else if (req.mode == tcb_pkg::MODE_READ || req.mode == tcb_pkg::MODE_WRITE) begin
            state_next = tcb_pkg::ST_LOOK;
          end else begin
            state_next = tcb_pkg::ST_DONE;
          end
        end
      end
      tcb_pkg::ST_PRE: begin
        bm_we    = 1'b1;
        bm_waddr = cur[MEMW-1:0];
        bm_wdata = wbyte;
        if (last_byte) begin
          state_next = tcb_pkg::ST_DONE;
        end
      end
      tcb_pkg::ST_LOOK: state_next = tcb_pkg::ST_CMP;
      tcb_pkg::ST_CMP: begin
        if (h0 || h1) begin
          state_next = tcb_pkg::ST_ACC;
        end else if (vic_dirty) begin
          state_next = tcb_pkg::ST_WB;
        end else begin
          state_next = tcb_pkg::ST_FILL;
        end
      end
      tcb_pkg::ST_WB: begin
        // read line byte cnt, write back byte cnt-1
        line_raddr = {op_port, idx, way, cnt_lo};
        bm_we      = (cnt != '0);
        bm_waddr   = wb_full[MEMW-1:0];
        bm_wdata   = line_rdata;
        if (cnt == LINE_END) begin
          state_next = tcb_pkg::ST_FILL;
        end
      end
      tcb_pkg::ST_FILL: begin
        line_we = (cnt != '0);
        if (cnt == LINE_END) begin
          tag_we              = 1'b1;
          meta_we             = 1'b1;
          meta_upd[way]       = 1'b1;
          meta_upd[{1'b1, way}] = 1'b0;
          state_next          = tcb_pkg::ST_ACC;
        end
      end
      tcb_pkg::ST_ACC: begin
        line_waddr  = {op_port, idx, way, off};
        line_wdata  = wbyte;
        meta_we     = 1'b1;
        meta_upd[4] = ~way;
        if (op_write) begin
          meta_upd[{1'b1, way}] = 1'b1;
          line_we    = 1'b1;
          state_next = last_byte ? tcb_pkg::ST_DONE : tcb_pkg::ST_LOOK;
        end else begin
          state_next = tcb_pkg::ST_RDW;
        end
      end
      tcb_pkg::ST_RDW: state_next = last_byte ? tcb_pkg::ST_DONE : tcb_pkg::ST_LOOK;
      tcb_pkg::ST_DONE: begin
        if (rsp.ready) begin
          state_next = tcb_pkg::ST_IDLE;
        end
      end
      default: state_next = tcb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == tcb_pkg::ST_CLR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // operation registers
  always_ff @(posedge clk) begin
    case (state)
      tcb_pkg::ST_IDLE: begin
        op_port  <= req.port;
        op_addr  <= req.address;
        op_wdata <= req.write_data;
        op_write <= (req.mode == tcb_pkg::MODE_WRITE) && (req.port == tcb_pkg::PORT_DATA);
        if (req.port != tcb_pkg::PORT_DATA && req.mode != tcb_pkg::MODE_PRELOAD) begin
          op_n <= 3'd4;
        end else if (req.access_size == tcb_pkg::SIZE_BYTE) begin
          op_n <= 3'd1;
        end else if (req.access_size == tcb_pkg::SIZE_HALF) begin
          op_n <= 3'd2;
        end else begin
          op_n <= 3'd4;
        end
        byte_i  <= '0;
        acc     <= '0;
        wb_any  <= 1'b0;
        hit_all <= (req.mode == tcb_pkg::MODE_READ) || (req.mode == tcb_pkg::MODE_WRITE);
      end
      tcb_pkg::ST_PRE: byte_i <= byte_i + 3'd1;
      tcb_pkg::ST_CMP: begin
        cnt  <= '0;
        meta <= meta_rd;
        if (h0 || h1) begin
          way <= h1 && !h0;
        end else begin
          way     <= vic;
          vtag    <= vict_tag;
          hit_all <= 1'b0;
          if (vic_dirty) begin
            wb_any <= 1'b1;
          end
        end
      end
      tcb_pkg::ST_WB: cnt <= (cnt == LINE_END) ? '0 : cnt + 1'b1;
      tcb_pkg::ST_FILL: begin
        cnt <= cnt + 1'b1;
        if (cnt == LINE_END) begin
          meta <= meta_upd;
        end
      end
      tcb_pkg::ST_ACC: begin
        if (op_write) begin
          byte_i <= byte_i + 3'd1;
        end
      end
      tcb_pkg::ST_RDW: begin
        acc    <= {acc[23:0], line_rdata};
        byte_i <= byte_i + 3'd1;
      end
      default: ;
    endcase
  end

  `TCB_ASSERT_IMP(a_clear_blocks, state == tcb_pkg::ST_CLR, !req.ready)
  `TCB_ASSERT_IMP(a_evict_is_miss, rsp.valid && rsp.dirty_evicted, !rsp.all_hit)
  `TCB_ASSERT_IMP(a_one_in_flight, req.ready, !rsp.valid)
  `TCB_ASSERT_NXT(a_accept_busy, req.valid && req.ready, !req.ready)
endmodule
